### hw/rtl/sdbt_pkg.sv
package sdbt_pkg;

   // table geometry
   localparam int unsigned TABLE_DEPTH_DEF = 1024;

   // field widths
   localparam int unsigned SECTOR_W   = 32;
   localparam int unsigned ADDR33_W   = 33;
   localparam int unsigned SLOT_W     = 10;
   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 144;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [31:0] UNALLOC = 32'hFFFF_FFFF;

   // action codes
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;

   // status codes
   localparam logic [1:0] STAT_MAPPED = 2'd0;
   localparam logic [1:0] STAT_HOLE   = 2'd1;
   localparam logic [1:0] STAT_ERROR  = 2'd2;
   localparam logic [1:0] STAT_LOADED = 2'd3;

   // register indexes
   localparam logic [2:0] REG_BLOCK_SHIFT    = 3'd0;
   localparam logic [2:0] REG_BITMAP_SECTORS = 3'd1;
   localparam logic [2:0] REG_TABLE_ENTRIES  = 3'd2;
   localparam logic [2:0] REG_DISK_SECTORS   = 3'd3;
   localparam logic [2:0] REG_DATA_START     = 3'd4;

   // register reset values
   localparam logic [3:0]  RST_BLOCK_SHIFT    = 4'd12;
   localparam logic [4:0]  RST_BITMAP_SECTORS = 5'd1;
   localparam logic [10:0] RST_TABLE_ENTRIES  = 11'd0;
   localparam logic [31:0] RST_DISK_SECTORS   = 32'd0;
   localparam logic [31:0] RST_DATA_START     = 32'd0;

   typedef struct packed {
      logic [32:0] footer_sector;
      logic        footer_write;
      logic [31:0] table_word;
      logic [9:0]  table_slot;
      logic        table_write;
      logic [32:0] bitmap_sector;
      logic        bitmap_write;
      logic [32:0] data_sector;
   } rsp_word_type;

endpackage

### hw/rtl/sdbt_ram.sv
module sdbt_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = sdbt_pkg::TABLE_DEPTH_DEF,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/sparse_disk_block_translator.sv
// a word is captured together with its table memory read, evaluated in the look step, and its result
// is registered onto rsp_tvalid; no new word is accepted until that result is registered, so the
// block takes one word at a time; a stalled result holds the block in the look step
// reset: clears the free pointer, the last-bitmap tracking and the handshake state, and
// returns the configuration registers to their defaults; the table memory is not cleared
module sparse_disk_block_translator #(
   parameter int unsigned TABLE_DEPTH = sdbt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sector [31:0], entry_index [41:32], entry_value [73:42], zero pad [79:74]
   input  logic [sdbt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action [1:0]
   input  logic [1:0]                        req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // data_sector [32:0], bitmap_write [33], bitmap_sector [66:34], table_write [67],
   // table_slot [77:68], table_word [109:78], footer_write [110], footer_sector [143:111]
   output logic [sdbt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status [1:0]
   output logic [1:0]                        rsp_tuser,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sdbt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [sdbt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [sdbt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // two-step sequencer: idle waits for a word, look evaluates the table read
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOOK = 1'b1;

   // ---------------------------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------------------------
   logic [3:0]  block_shift_ff;
   logic [4:0]  bitmap_sectors_ff;
   logic [10:0] table_entries_ff;
   logic [31:0] disk_sectors_ff;
   logic [31:0] data_start_ff;
   logic        csr_wr;
   logic [2:0]  csr_index;

   assign pready    = 1'b1;
   assign csr_wr    = psel & penable & pwrite & pready;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         block_shift_ff    <= sdbt_pkg::RST_BLOCK_SHIFT;
         bitmap_sectors_ff <= sdbt_pkg::RST_BITMAP_SECTORS;
         table_entries_ff  <= sdbt_pkg::RST_TABLE_ENTRIES;
         disk_sectors_ff   <= sdbt_pkg::RST_DISK_SECTORS;
         data_start_ff     <= sdbt_pkg::RST_DATA_START;
      end else if (csr_wr) begin
         unique case (csr_index)
            sdbt_pkg::REG_BLOCK_SHIFT:    block_shift_ff    <= pwdata[3:0];
            sdbt_pkg::REG_BITMAP_SECTORS: bitmap_sectors_ff <= pwdata[4:0];
            sdbt_pkg::REG_TABLE_ENTRIES:  table_entries_ff  <= pwdata[10:0];
            sdbt_pkg::REG_DISK_SECTORS:   disk_sectors_ff   <= pwdata;
            sdbt_pkg::REG_DATA_START:     data_start_ff     <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         sdbt_pkg::REG_BLOCK_SHIFT:    prdata = 32'(block_shift_ff);
         sdbt_pkg::REG_BITMAP_SECTORS: prdata = 32'(bitmap_sectors_ff);
         sdbt_pkg::REG_TABLE_ENTRIES:  prdata = 32'(table_entries_ff);
         sdbt_pkg::REG_DISK_SECTORS:   prdata = disk_sectors_ff;
         sdbt_pkg::REG_DATA_START:     prdata = data_start_ff;
         default:                      prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // request capture and table read
   // ---------------------------------------------------------------------------------------
   logic        state_ff, state_in;
   logic        req_acc;
   logic [1:0]  action_ff;
   logic [31:0] sector_ff;
   logic [9:0]  eidx_ff;
   logic [31:0] evalue_ff;
   logic [31:0] req_bidx;
   logic [AW-1:0] ram_raddr;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;

   // block index of the incoming sector addresses the table straight away
   assign req_bidx  = req_tdata[31:0] >> block_shift_ff;
   assign ram_raddr = req_bidx[AW-1:0];

   always_ff @(posedge clock) begin
      if (req_acc) begin
         action_ff <= req_tuser;
         sector_ff <= req_tdata[31:0];
         eidx_ff   <= req_tdata[41:32];
         evalue_ff <= req_tdata[73:42];
      end
   end

   // ---------------------------------------------------------------------------------------
   // evaluate step
   // ---------------------------------------------------------------------------------------
   logic        look;
   logic        out_free;
   logic        step;
   logic [31:0] ram_rdata;
   logic        ram_we;
   logic [AW-1:0] ram_waddr;
   logic [31:0] ram_wdata;

   logic [32:0] free_ptr_ff, free_ptr_in;
   logic [31:0] last_bitmap_ff, last_bitmap_in;
   logic        last_valid_ff, last_valid_in;

   logic [32:0] bsize;
   logic [31:0] bidx;
   logic [32:0] blk_offset;
   logic [31:0] limit;
   logic        in_table;
   logic [31:0] entry;
   logic [32:0] eff_free;
   logic [32:0] load_next;
   logic [31:0] eidx_wide;
   logic        eidx_ok;

   sdbt_pkg::rsp_word_type res;
   logic [1:0]             res_status;

   assign look      = (state_ff == ST_LOOK);
   assign out_free  = ~rsp_tvalid | rsp_tready;
   assign step      = look & out_free;

   assign bsize      = 33'd1 << block_shift_ff;
   assign bidx       = sector_ff >> block_shift_ff;
   assign blk_offset = 33'(sector_ff) & (bsize - 33'd1);
   assign limit     = (32'(table_entries_ff) < 32'(TABLE_DEPTH)) ? 32'(table_entries_ff)
                                                                  : 32'(TABLE_DEPTH);
   assign in_table  = bidx < limit;
   assign entry     = in_table ? ram_rdata : sdbt_pkg::UNALLOC;
   assign eff_free  = (free_ptr_ff > 33'(data_start_ff)) ? free_ptr_ff : 33'(data_start_ff);
   assign load_next = 33'(evalue_ff) + 33'(bitmap_sectors_ff) + bsize;
   assign eidx_wide = 32'(eidx_ff);
   assign eidx_ok   = eidx_wide < 32'(TABLE_DEPTH);

   always_comb begin
      res            = '0;
      res_status     = sdbt_pkg::STAT_ERROR;
      ram_we         = 1'b0;
      ram_waddr      = bidx[AW-1:0];
      ram_wdata      = eff_free[31:0];
      free_ptr_in    = free_ptr_ff;
      last_bitmap_in = last_bitmap_ff;
      last_valid_in  = last_valid_ff;

      case (action_ff)
         sdbt_pkg::ACT_LOAD: begin
            if (eidx_ok) begin
               res_status = sdbt_pkg::STAT_LOADED;
               ram_we     = step;
               ram_waddr  = eidx_wide[AW-1:0];
               ram_wdata  = evalue_ff;
               // loaded block pushes the free pointer past its end
               if (evalue_ff != sdbt_pkg::UNALLOC && load_next > free_ptr_ff) begin
                  free_ptr_in = load_next;
               end
            end
         end
         sdbt_pkg::ACT_READ, sdbt_pkg::ACT_WRITE: begin
            if (entry != sdbt_pkg::UNALLOC) begin
               res_status      = sdbt_pkg::STAT_MAPPED;
               res.data_sector = 33'(entry) + 33'(bitmap_sectors_ff) + blk_offset;
               // bitmap rewrite only when the block changes
               if (action_ff == sdbt_pkg::ACT_WRITE &&
                   (!last_valid_ff || last_bitmap_ff != entry)) begin
                  last_bitmap_in    = entry;
                  last_valid_in     = 1'b1;
                  res.bitmap_write  = 1'b1;
                  res.bitmap_sector = 33'(entry);
               end
            end else if (action_ff == sdbt_pkg::ACT_READ) begin
               res_status = sdbt_pkg::STAT_HOLE;
            end else if (in_table && sector_ff < disk_sectors_ff &&
                         eff_free < 33'(sdbt_pkg::UNALLOC)) begin
               // allocate a fresh block at the end of the image
               res_status        = sdbt_pkg::STAT_MAPPED;
               ram_we            = step;
               free_ptr_in       = eff_free + bsize + 33'(bitmap_sectors_ff);
               res.data_sector   = eff_free + 33'(bitmap_sectors_ff) + blk_offset;
               res.bitmap_write  = 1'b1;
               res.bitmap_sector = eff_free;
               res.table_write   = 1'b1;
               res.table_slot    = bidx[9:0];
               res.table_word    = eff_free[31:0];
               res.footer_write  = 1'b1;
               res.footer_sector = free_ptr_in;
            end
         end
         default: ;
      endcase
   end

   sdbt_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (req_acc),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---------------------------------------------------------------------------------------
   // sequencer and tracking state
   // ---------------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_acc) state_in = ST_LOOK;
         ST_LOOK: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         free_ptr_ff    <= '0;
         last_bitmap_ff <= '0;
         last_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (step) begin
            free_ptr_ff    <= free_ptr_in;
            last_bitmap_ff <= last_bitmap_in;
            last_valid_ff  <= last_valid_in;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------------------------
   logic                   rsp_valid_ff, rsp_valid_in;
   sdbt_pkg::rsp_word_type rsp_word_ff;
   logic [1:0]             rsp_status_ff;

   always_comb begin
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_word_ff   <= res;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_status_ff;

   // ---------------------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------------------
   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_LOOK)
      else $error("accepted word did not move to evaluate step");

   a_write_in_look: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> look && out_free)
      else $error("table write outside evaluate step");

   a_rsp_from_look: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_LOOK)
      else $error("response raised without evaluate step");

   a_stall_holds_look: assert property (@(posedge clock) disable iff (reset)
      look && !out_free |=> state_ff == ST_LOOK)
      else $error("evaluate step left while output was blocked");

   a_free_ptr_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> free_ptr_ff >= $past(free_ptr_ff))
      else $error("free pointer moved backward");

endmodule
